// ===== rtl/core/lss_pkg.sv =====
package lss_pkg;

  // Stack geometry
  localparam int DEPTH_DEF   = 16;
  localparam int MAX_RESULTS = 16;

  // Request operations
  localparam logic [1:0] MODE_PUSH   = 2'd0;
  localparam logic [1:0] MODE_POP    = 2'd1;
  localparam logic [1:0] MODE_SEARCH = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_PUSHED    = 3'd0;
  localparam logic [2:0] ST_OVERFLOW  = 3'd1;
  localparam logic [2:0] ST_POPPED    = 3'd2;
  localparam logic [2:0] ST_UNDERFLOW = 3'd3;
  localparam logic [2:0] ST_FOUND     = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND = 3'd5;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] data;
    logic [3:0]         position;
    logic               last;
  } out_t;

endpackage

// ===== rtl/core/lss_mem.sv =====
// Single-port stack store, registered read.
module lss_mem #(
  parameter int Depth = lss_pkg::DEPTH_DEF,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [AddrW-1:0]        addr,
  input  logic signed [31:0]      wr_data,
  output logic signed [31:0]      rd_data
);

  logic signed [31:0] mem [Depth];
  logic signed [31:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/lss_ctrl.sv =====
// Sequencer: push/pop handling and the search walk over the store with a
// single 32-bit comparator. One match is held back so the final one can carry last.
module lss_ctrl #(
  parameter int Depth = lss_pkg::DEPTH_DEF,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lss_pkg::in_t         in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lss_pkg::out_t        out_data,
  output logic                 mem_wr_en,
  output logic [AddrW-1:0]     mem_addr,
  output logic signed [31:0]   mem_wr_data,
  input  logic signed [31:0]   mem_rd_data
);

  localparam int FillW = $clog2(Depth + 1);
  localparam int CntW  = $clog2(lss_pkg::MAX_RESULTS + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_POP   = 2'd1;
  localparam logic [1:0] S_CMP   = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [FillW-1:0]   fill_r, fill_nxt;
  logic [AddrW-1:0]   idx_r, idx_nxt;
  logic [CntW-1:0]    cnt_r, cnt_nxt;
  logic               pend_valid_r, pend_valid_nxt;
  logic [3:0]         pend_pos_r, pend_pos_nxt;
  logic signed [31:0] key_r, key_nxt;
  logic               out_valid_r, out_valid_nxt;
  lss_pkg::out_t      out_r, out_nxt;

  logic               can_emit;
  logic               full;
  logic               empty;
  logic [FillW-1:0]   fill_m1;
  logic [AddrW+3:0]   idx_ext;
  logic               hit;
  logic               last_ent;
  logic               cap;

  assign can_emit = !out_valid_r || out_ready;
  assign full     = (fill_r == FillW'(Depth));
  assign empty    = (fill_r == '0);
  assign fill_m1  = fill_r - FillW'(1);
  assign idx_ext  = {4'b0, idx_r};
  assign hit      = (mem_rd_data == key_r);
  assign last_ent = ((FillW'(idx_r) + FillW'(1)) == fill_r);
  assign cap      = hit && (cnt_r == CntW'(lss_pkg::MAX_RESULTS - 1));

  assign mem_wr_data = in_data.value;

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    pend_valid_nxt = pend_valid_r;
    pend_pos_nxt   = pend_pos_r;
    key_nxt        = key_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_nxt        = out_r;
    mem_wr_en      = 1'b0;
    mem_addr       = idx_r;
    in_ready       = (state_r == S_IDLE) && can_emit;

    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          case (in_data.mode)
            lss_pkg::MODE_PUSH: begin
              out_valid_nxt = 1'b1;
              if (full) begin
                out_nxt = '{lss_pkg::ST_OVERFLOW, 32'sd0, 4'd0, 1'b1};
              end else begin
                mem_wr_en = 1'b1;
                mem_addr  = fill_r[AddrW-1:0];
                fill_nxt  = fill_r + FillW'(1);
                out_nxt   = '{lss_pkg::ST_PUSHED, 32'sd0, 4'd0, 1'b1};
              end
            end
            lss_pkg::MODE_POP: begin
              if (empty) begin
                out_valid_nxt = 1'b1;
                out_nxt = '{lss_pkg::ST_UNDERFLOW, 32'sd0, 4'd0, 1'b1};
              end else begin
                fill_nxt  = fill_m1;
                mem_addr  = fill_m1[AddrW-1:0];
                state_nxt = S_POP;
              end
            end
            lss_pkg::MODE_SEARCH: begin
              key_nxt        = in_data.value;
              pend_valid_nxt = 1'b0;
              cnt_nxt        = '0;
              idx_nxt        = '0;
              mem_addr       = '0;
              state_nxt      = empty ? S_FLUSH : S_CMP;
            end
            default: begin
              // unused opcode: taken and dropped
            end
          endcase
        end
      end
      S_POP: begin
        // output register was free at accept
        out_valid_nxt = 1'b1;
        out_nxt       = '{lss_pkg::ST_POPPED, mem_rd_data, 4'd0, 1'b1};
        state_nxt     = S_IDLE;
      end
      S_CMP: begin
        if (hit && pend_valid_r && !can_emit) begin
          mem_addr = idx_r;  // hold read data while stalled
        end else begin
          if (hit) begin
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_nxt = '{lss_pkg::ST_FOUND, 32'sd0, pend_pos_r, 1'b0};
            end
            pend_valid_nxt = 1'b1;
            pend_pos_nxt   = idx_ext[3:0];
            cnt_nxt        = cnt_r + CntW'(1);
          end
          if (last_ent || cap) begin
            state_nxt = S_FLUSH;
          end else begin
            idx_nxt  = idx_r + AddrW'(1);
            mem_addr = idx_r + AddrW'(1);
          end
        end
      end
      S_FLUSH: begin
        if (can_emit) begin
          out_valid_nxt  = 1'b1;
          if (pend_valid_r) begin
            out_nxt = '{lss_pkg::ST_FOUND, 32'sd0, pend_pos_r, 1'b1};
          end else begin
            out_nxt = '{lss_pkg::ST_NOT_FOUND, 32'sd0, 4'd0, 1'b1};
          end
          pend_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fill_r       <= '0;
      cnt_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_r       <= fill_nxt;
      cnt_r        <= cnt_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    pend_pos_r <= pend_pos_nxt;
    key_r      <= key_nxt;
    out_r      <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FillW'(Depth))
    else $error("fill level beyond depth");

  a_search_fill_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP || state_r == S_FLUSH) |=> $stable(fill_r))
    else $error("fill level moved during search");

  a_no_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_POP) |-> !pend_valid_r)
    else $error("held match left over outside search");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(lss_pkg::MAX_RESULTS))
    else $error("match count beyond limit");
`endif

endmodule

// ===== rtl/core/lifo_stack_with_search.sv =====
// Bounded LIFO stack of signed 32-bit words with push, pop and linear search.
//
// Request channel (in_valid/in_ready/in_data): mode 0 push, 1 pop, 2 search;
// value is the word to push or the key to look for. Mode 3 is taken and dropped.
// Result channel (out_valid/out_ready/out_data): status, popped data, match
// position and last. Push and pop give one result each; a search gives one
// result per matching entry, bottom first (capped at MAX_RESULTS), or a
// single not-found result. last marks the final result of each request.
//
// Timing: a pop reads the store through its registered read port in S_POP; a
// search walks the store with the one comparator at the pace of the store's single
// port, one entry a cycle unless a match waits on a busy output register. One
// request at a time; in_ready is low while a pop or search is in progress.
// Results sit in an output register; a stalled receiver holds it, and a
// search walk pauses on the next match until the register frees up.
// Reset (rst_n low, synchronous) empties the stack and drops any result;
// the store contents are not cleared and need no clearing pass.
module lifo_stack_with_search #(
  parameter int Depth = lss_pkg::DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  lss_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output lss_pkg::out_t out_data
);

  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic                mem_wr_en;
  logic [AddrW-1:0]    mem_addr;
  logic signed [31:0]  mem_wr_data;
  logic signed [31:0]  mem_rd_data;

  // sequencer and comparator
  lss_ctrl #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .mem_wr_en   (mem_wr_en),
    .mem_addr    (mem_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_data (mem_rd_data)
  );

  // entry store
  lss_mem #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .addr    (mem_addr),
    .wr_data (mem_wr_data),
    .rd_data (mem_rd_data)
  );

endmodule
